FILE: rtl/core/segment_sphere_crossing_test_top_assert.svh
// Assertion macros for the segment sphere crossing test.
`ifndef SEGMENT_SPHERE_CROSSING_TEST_TOP_ASSERT_SVH
`define SEGMENT_SPHERE_CROSSING_TEST_TOP_ASSERT_SVH
// Checked while out of reset.
`define SSCT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define SSCT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: rtl/core/ssct_pkg.sv
// Package of shared constants for the segment sphere crossing test.
`default_nettype none
package ssct_pkg;
   localparam int COORD_BITS_DEF = 24;
endpackage
`default_nettype wire

FILE: rtl/core/ssct_if.sv
// Request and response channel interfaces.
`default_nettype none
interface ssct_req_if #(parameter int COORD_BITS = ssct_pkg::COORD_BITS_DEF);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] start_x, start_y, start_z;
   logic [COORD_BITS-1:0] end_x, end_y, end_z;
   logic [COORD_BITS-1:0] center_x, center_y, center_z;
   logic [COORD_BITS-2:0] sphere_radius;
   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   center_x, center_y, center_z, sphere_radius, input ready);
   modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface ssct_rsp_if;
   logic valid;
   logic ready;
   logic crossing;
   logic degenerate;
   modport source (output valid, crossing, degenerate, input ready);
   modport sink (input valid, crossing, degenerate, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ssct_wmul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
`default_nettype none
module ssct_wmul #(
   parameter int AW = 52,
   parameter int BW = 52
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [AW-1:0]    a,
   input  wire logic [BW-1:0]    b,
   output logic      [AW+BW-1:0] p
);
   localparam int AL = (AW + 1) / 2;
   localparam int AH = AW - AL;
   localparam int BL = (BW + 1) / 2;
   localparam int BH = BW - BL;
   localparam int PW = AW + BW;

   logic [AL+BL-1:0] ll_ff, ll_in;
   logic [AL+BH-1:0] lh_ff, lh_in;
   logic [AH+BL-1:0] hl_ff, hl_in;
   logic [AH+BH-1:0] hh_ff, hh_in;
   logic [PW-1:0]    p_ff, p_in;

   always_comb begin
      ll_in = a[AL-1:0] * b[BL-1:0];
      lh_in = a[AL-1:0] * b[BW-1:BL];
      hl_in = a[AW-1:AL] * b[BL-1:0];
      hh_in = a[AW-1:AL] * b[BW-1:BL];
      p_in  = PW'(ll_ff) + (PW'(lh_ff) << BL) + (PW'(hl_ff) << AL)
            + (PW'(hh_ff) << (AL + BL));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;
endmodule
`default_nettype wire

FILE: rtl/core/segment_sphere_crossing_test_top.sv
// Segment against sphere crossing test: eight-stage pipeline, exact integer arithmetic.
// Throughput is one word per cycle; the whole pipeline holds while the response is stalled.
// The wide squares and the radius product go through two-stage split multipliers.
// Reset is synchronous and clears only the stage valid bits; data registers are not reset.
`default_nettype none
`include "segment_sphere_crossing_test_top_assert.svh"
module segment_sphere_crossing_test_top #(
   parameter int COORD_BITS = ssct_pkg::COORD_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   ssct_req_if.sink  req_ch,
   ssct_rsp_if.source rsp_ch
);
   localparam int N   = COORD_BITS;
   localparam int DW  = N + 1;      // coordinate differences
   localparam int PW  = 2 * DW;     // signed products
   localparam int KW  = PW + 1;     // cross product terms, signed
   localparam int CW  = PW + 1;     // squared lengths, unsigned
   localparam int SW  = PW + 2;     // dot products, signed
   localparam int RW  = N - 1;
   localparam int R2W = 2 * RW;
   localparam int K2W = 2 * KW + 2;
   localparam int RCW = R2W + CW;

   logic en;
   logic [8:1] v_ff;

   assign en           = !v_ff[8] || rsp_ch.ready;
   assign req_ch.ready = en;

   // stage 1: differences
   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff, ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;
   logic signed [DW-1:0] dx_in, dy_in, dz_in, ux_in, uy_in, uz_in, vx_in, vy_in, vz_in;
   logic [RW-1:0] r1_ff;
   logic          dg1_ff, dg1_in;

   function automatic logic signed [DW-1:0] sdiff(input logic [N-1:0] a,
                                                  input logic [N-1:0] b);
      return $signed({a[N-1], a}) - $signed({b[N-1], b});
   endfunction

   always_comb begin
      dx_in  = sdiff(req_ch.end_x, req_ch.start_x);
      dy_in  = sdiff(req_ch.end_y, req_ch.start_y);
      dz_in  = sdiff(req_ch.end_z, req_ch.start_z);
      ux_in  = sdiff(req_ch.center_x, req_ch.start_x);
      uy_in  = sdiff(req_ch.center_y, req_ch.start_y);
      uz_in  = sdiff(req_ch.center_z, req_ch.start_z);
      vx_in  = sdiff(req_ch.center_x, req_ch.end_x);
      vy_in  = sdiff(req_ch.center_y, req_ch.end_y);
      vz_in  = sdiff(req_ch.center_z, req_ch.end_z);
      dg1_in = (req_ch.start_x == req_ch.end_x) && (req_ch.start_y == req_ch.end_y)
            && (req_ch.start_z == req_ch.end_z);
   end

   // stage 2: products
   logic signed [PW-1:0] p_dyuz_ff, p_dzuy_ff, p_dzux_ff, p_dxuz_ff, p_dxuy_ff, p_dyux_ff;
   logic signed [PW-1:0] p_dd_ff [3];
   logic signed [PW-1:0] p_uu_ff [3];
   logic signed [PW-1:0] p_du_ff [3];
   logic signed [PW-1:0] p_dv_ff [3];
   logic [R2W-1:0]       r2_2_ff;
   logic                 dg2_ff;

   // stage 3: sums
   logic signed [KW-1:0] kx_ff, ky_ff, kz_ff, kx_in, ky_in, kz_in;
   logic signed [SW-1:0] c2s_in, u2s_in, dus_ff, dvs_ff, dus_in, dvs_in;
   logic [CW-1:0]        c2_3_ff, u2_3_ff;
   logic [R2W-1:0]       r2_3_ff;
   logic                 dg3_ff;

   always_comb begin
      kx_in  = KW'(p_dyuz_ff) - KW'(p_dzuy_ff);
      ky_in  = KW'(p_dzux_ff) - KW'(p_dxuz_ff);
      kz_in  = KW'(p_dxuy_ff) - KW'(p_dyux_ff);
      c2s_in = SW'(p_dd_ff[0]) + SW'(p_dd_ff[1]) + SW'(p_dd_ff[2]);
      u2s_in = SW'(p_uu_ff[0]) + SW'(p_uu_ff[1]) + SW'(p_uu_ff[2]);
      dus_in = SW'(p_du_ff[0]) + SW'(p_du_ff[1]) + SW'(p_du_ff[2]);
      dvs_in = SW'(p_dv_ff[0]) + SW'(p_dv_ff[1]) + SW'(p_dv_ff[2]);
   end

   // stage 4: magnitudes
   logic [KW-1:0]  ka_ff [3];
   logic [KW-1:0]  ka_in [3];
   logic [SW-1:0]  dua_ff, dva_ff, dua_in, dva_in;
   logic [CW-1:0]  c2_4_ff, u2_4_ff;
   logic [R2W-1:0] r2_4_ff;
   logic           dg4_ff;

   function automatic logic [KW-1:0] kabs(input logic signed [KW-1:0] x);
      return x[KW-1] ? KW'(-x) : KW'(x);
   endfunction

   always_comb begin
      ka_in[0] = kabs(kx_ff);
      ka_in[1] = kabs(ky_ff);
      ka_in[2] = kabs(kz_ff);
      dua_in   = dus_ff[SW-1] ? SW'(-dus_ff) : SW'(dus_ff);
      dva_in   = dvs_ff[SW-1] ? SW'(-dvs_ff) : SW'(dvs_ff);
   end

   // stages 5 and 6: wide squares and the radius product in the split multipliers, flags delayed alongside
   logic [2*KW-1:0] ksq [3];
   logic [RCW-1:0]  r2c2;
   logic            oku5_ff, pt5_ff, dg5_ff, oku6_ff, pt6_ff, dg6_ff;

   for (genvar g = 0; g < 3; g++) begin : g_ksq
      ssct_wmul #(.AW(KW), .BW(KW)) u_ksq (
         .clock(clock), .en(en), .a(ka_ff[g]), .b(ka_ff[g]), .p(ksq[g]));
   end

   ssct_wmul #(.AW(R2W), .BW(CW)) u_r2c2 (
      .clock(clock), .en(en), .a(r2_4_ff), .b(c2_4_ff), .p(r2c2));

   // stage 7: sum of the cross product squares
   logic [K2W-1:0] k2_ff, k2_in;
   logic [RCW-1:0] r2c2_7_ff;
   logic           oku7_ff, pt7_ff, dg7_ff;

   assign k2_in = K2W'(ksq[0]) + K2W'(ksq[1]) + K2W'(ksq[2]);

   // stage 8: final compare into the response register
   logic crossing_ff, crossing_in, degen_ff;

   always_comb begin
      if (dg7_ff) begin
         crossing_in = pt7_ff;
      end else begin
         crossing_in = oku7_ff && (K2W'(k2_ff) <= K2W'(r2c2_7_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[7:1], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= dx_in; dy_ff <= dy_in; dz_ff <= dz_in;
         ux_ff <= ux_in; uy_ff <= uy_in; uz_ff <= uz_in;
         vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in;
         r1_ff  <= req_ch.sphere_radius;
         dg1_ff <= dg1_in;

         p_dyuz_ff <= dy_ff * uz_ff;
         p_dzuy_ff <= dz_ff * uy_ff;
         p_dzux_ff <= dz_ff * ux_ff;
         p_dxuz_ff <= dx_ff * uz_ff;
         p_dxuy_ff <= dx_ff * uy_ff;
         p_dyux_ff <= dy_ff * ux_ff;
         p_dd_ff[0] <= dx_ff * dx_ff;
         p_dd_ff[1] <= dy_ff * dy_ff;
         p_dd_ff[2] <= dz_ff * dz_ff;
         p_uu_ff[0] <= ux_ff * ux_ff;
         p_uu_ff[1] <= uy_ff * uy_ff;
         p_uu_ff[2] <= uz_ff * uz_ff;
         p_du_ff[0] <= dx_ff * ux_ff;
         p_du_ff[1] <= dy_ff * uy_ff;
         p_du_ff[2] <= dz_ff * uz_ff;
         p_dv_ff[0] <= dx_ff * vx_ff;
         p_dv_ff[1] <= dy_ff * vy_ff;
         p_dv_ff[2] <= dz_ff * vz_ff;
         r2_2_ff    <= r1_ff * r1_ff;
         dg2_ff     <= dg1_ff;

         kx_ff   <= kx_in; ky_ff <= ky_in; kz_ff <= kz_in;
         c2_3_ff <= CW'(c2s_in);
         u2_3_ff <= CW'(u2s_in);
         dus_ff  <= dus_in;
         dvs_ff  <= dvs_in;
         r2_3_ff <= r2_2_ff;
         dg3_ff  <= dg2_ff;

         ka_ff   <= ka_in;
         dua_ff  <= dua_in;
         dva_ff  <= dva_in;
         c2_4_ff <= c2_3_ff;
         u2_4_ff <= u2_3_ff;
         r2_4_ff <= r2_3_ff;
         dg4_ff  <= dg3_ff;

         oku5_ff <= (SW'(c2_4_ff) >= dua_ff) && (SW'(c2_4_ff) >= dva_ff);
         pt5_ff  <= CW'(r2_4_ff) >= u2_4_ff;
         dg5_ff  <= dg4_ff;
         oku6_ff <= oku5_ff; pt6_ff <= pt5_ff; dg6_ff <= dg5_ff;

         k2_ff     <= k2_in;
         r2c2_7_ff <= r2c2;
         oku7_ff   <= oku6_ff; pt7_ff <= pt6_ff; dg7_ff <= dg6_ff;

         crossing_ff <= crossing_in;
         degen_ff    <= dg7_ff;
      end
   end

   assign rsp_ch.valid      = v_ff[8];
   assign rsp_ch.crossing   = crossing_ff;
   assign rsp_ch.degenerate = degen_ff;

   // A stalled response word must hold the whole pipeline, input included.
   `SSCT_ASSERT(a_stall_blocks_input, clock, reset,
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready, "input taken during output stall")
   // The edge after a reset edge shows no response word.
   `SSCT_ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> !rsp_ch.valid, "response valid straight after reset")
   // A word accepted into an empty-output pipeline advances one stage.
   `SSCT_ASSERT(a_entry_moves, clock, reset,
      req_ch.valid && req_ch.ready |=> v_ff[1], "accepted word lost at entry")
endmodule
`default_nettype wire
